[hw/rtl/mspid_pkg.sv]
// Shared types and constants for the motor speed PID / ramp regulator.
// Depends on nothing; mspid_calc, the top level and the testbench import it.
package mspid_pkg;

	// Default number of motor channels
	localparam int CHANNELS_DEF = 2;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP    = 3'd5;

	// Regulation modes
	localparam logic MODE_PID  = 1'b0;
	localparam logic MODE_RAMP = 1'b1;

	// Register reset values
	localparam logic [15:0] PROP_GAIN_RST  = 16'd6400;
	localparam logic [15:0] INT_GAIN_RST   = 16'd512;
	localparam logic [15:0] DERIV_GAIN_RST = 16'd2560;
	localparam logic [14:0] RAMP_LIMIT_RST = 15'd38;
	localparam logic [7:0]  RAMP_STEP_RST  = 8'd1;

	// Drive saturation limit
	localparam int DRIVE_MAX = 255;

	typedef struct packed {
		logic        control_mode;
		logic [15:0] prop_gain;
		logic [15:0] int_gain;
		logic [15:0] deriv_gain;
		logic [14:0] ramp_limit;
		logic [7:0]  ramp_step;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] error_integral;
		logic signed [15:0] previous_error;
		logic signed [15:0] previous_speed;
		logic signed [8:0]  drive_level;
	} chan_state_t;

	typedef struct packed {
		logic [7:0] drive_magnitude;
		logic       drive_reverse;
		logic       drive_clamped;
	} drive_res_t;

endpackage

[hw/rtl/mspid_if.sv]
// Valid/ready channel interfaces for control ticks and drive results.
// Depends on nothing.
interface mspid_tick_if;
	logic               valid;
	logic               ready;
	logic               motor_index;
	logic signed [15:0] measured_speed;
	logic signed [15:0] speed_err;

	modport source (output valid, motor_index, measured_speed, speed_err, input ready);
	modport sink   (input valid, motor_index, measured_speed, speed_err, output ready);
endinterface

interface mspid_drive_if;
	logic       valid;
	logic       ready;
	logic       channel_out;
	logic [7:0] drive_magnitude;
	logic       drive_reverse;
	logic       drive_clamped;

	modport source (output valid, channel_out, drive_magnitude, drive_reverse, drive_clamped,
		input ready);
	modport sink   (input valid, channel_out, drive_magnitude, drive_reverse, drive_clamped,
		output ready);
endinterface

[hw/rtl/mspid_calc.sv]
// One control step: PID with trapezoidal integral, or fixed-step ramp, then clamp.
// Depends on mspid_pkg. Purely combinational.
module mspid_calc (
	input  mspid_pkg::cfg_t        cfg,
	input  mspid_pkg::chan_state_t state_cur,
	input  logic signed [15:0]     measured_speed,
	input  logic signed [15:0]     speed_err,
	output mspid_pkg::chan_state_t state_nxt,
	output mspid_pkg::drive_res_t  res
);
	import mspid_pkg::*;

	logic signed [33:0] sum_wide;
	logic signed [31:0] sum_sat;
	logic signed [16:0] delta;
	logic signed [32:0] p_prod;
	logic signed [48:0] i_prod;
	logic signed [33:0] d_prod;
	logic signed [50:0] acc;
	logic signed [50:0] acc_adj;
	logic signed [33:0] pid_drive;
	logic signed [10:0] ramp_drive;
	logic signed [16:0] limit_s;
	logic signed [33:0] raw_drive;
	logic signed [8:0]  drive;
	logic               clamped;

	// Saturating trapezoidal integral and speed difference
	always_comb begin
		sum_wide = 34'(state_cur.error_integral) + 34'(speed_err)
			+ 34'(state_cur.previous_error);
		if (sum_wide > 34'sd2147483647)
			sum_sat = 32'sh7FFFFFFF;
		else if (sum_wide < -34'sd2147483648)
			sum_sat = 32'sh80000000;
		else
			sum_sat = sum_wide[31:0];
		delta = 17'(measured_speed) - 17'(state_cur.previous_speed);
	end

	// Three gain products, side by side
	assign p_prod = 33'($signed({1'b0, cfg.prop_gain})) * 33'(speed_err);
	assign i_prod = 49'($signed({1'b0, cfg.int_gain})) * 49'(sum_sat);
	assign d_prod = 34'($signed({1'b0, cfg.deriv_gain})) * 34'(delta);

	// Combine in Q.17 and truncate toward zero
	always_comb begin
		acc = (51'(p_prod) <<< 1) + 51'(i_prod) - (51'(d_prod) <<< 1);
		acc_adj = acc[50] ? acc + 51'sd131071 : acc;
		pid_drive = 34'(acc_adj >>> 17);
	end

	// Ramp: step the stored drive outside the dead band
	always_comb begin
		limit_s = $signed({2'b00, cfg.ramp_limit});
		ramp_drive = 11'(state_cur.drive_level);
		if (17'(speed_err) > limit_s)
			ramp_drive = 11'(state_cur.drive_level) + $signed({3'b000, cfg.ramp_step});
		else if (17'(speed_err) < -limit_s)
			ramp_drive = 11'(state_cur.drive_level) - $signed({3'b000, cfg.ramp_step});
	end

	// Clamp to the drive range
	always_comb begin
		raw_drive = (cfg.control_mode == MODE_RAMP) ? 34'(ramp_drive) : pid_drive;
		clamped = 1'b0;
		if (raw_drive > 34'(DRIVE_MAX)) begin
			drive = 9'(DRIVE_MAX);
			clamped = 1'b1;
		end else if (raw_drive < -34'(DRIVE_MAX)) begin
			drive = -9'(DRIVE_MAX);
			clamped = 1'b1;
		end else begin
			drive = raw_drive[8:0];
		end
	end

	// Next channel state: ramp mode moves only the drive level
	always_comb begin
		state_nxt = state_cur;
		state_nxt.drive_level = drive;
		if (cfg.control_mode == MODE_PID) begin
			state_nxt.error_integral = sum_sat;
			state_nxt.previous_error = speed_err;
			state_nxt.previous_speed = measured_speed;
		end
	end

	// Magnitude and direction
	assign res.drive_magnitude = drive[8] ? 8'(-drive) : drive[7:0];
	assign res.drive_reverse   = drive[8];
	assign res.drive_clamped   = clamped;

endmodule

[hw/rtl/motor_speed_pid_with_ramp.sv]
// Motor speed regulator, PID or fixed-step ramp, per-channel state.
// Result path: the tick is captured in the input register, then its result in the result register.
// Throughput: one tick per cycle unless the result side stalls; the whole step is one pass
// between the two registers, with channel state written as the result is registered.
// Reset: arst_n clears channel state, restores register defaults and empties both stages.
// Depends on mspid_pkg, mspid_if and mspid_calc.
module motor_speed_pid_with_ramp #(
	parameter int CHANNELS = mspid_pkg::CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mspid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mspid_pkg::CFG_DATA_W-1:0]  cfg_data,
	mspid_tick_if.sink                        tick,
	mspid_drive_if.source                     drive
);
	import mspid_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	cfg_t        cfg_q;
	chan_state_t state_q [CHANNELS];

	logic               valid_s1;
	logic               idx_s1;
	logic signed [15:0] speed_s1;
	logic signed [15:0] err_s1;

	logic       out_valid_q;
	logic       channel_q;
	drive_res_t res_q;

	logic [CH_W-1:0] ch;
	logic            advance;
	chan_state_t     state_nxt;
	drive_res_t      res;

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.control_mode <= MODE_PID;
			cfg_q.prop_gain    <= PROP_GAIN_RST;
			cfg_q.int_gain     <= INT_GAIN_RST;
			cfg_q.deriv_gain   <= DERIV_GAIN_RST;
			cfg_q.ramp_limit   <= RAMP_LIMIT_RST;
			cfg_q.ramp_step    <= RAMP_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONTROL_MODE: cfg_q.control_mode <= cfg_data[0];
				REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data[15:0];
				REG_INT_GAIN:     cfg_q.int_gain     <= cfg_data[15:0];
				REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data[15:0];
				REG_RAMP_LIMIT:   cfg_q.ramp_limit   <= cfg_data[14:0];
				REG_RAMP_STEP:    cfg_q.ramp_step    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on when the result register is free or being drained
	assign advance    = valid_s1 && (!out_valid_q || drive.ready);
	assign tick.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	// Hold the tick payload on transfer
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			idx_s1   <= tick.motor_index;
			speed_s1 <= tick.measured_speed;
			err_s1   <= tick.speed_err;
		end
	end

	// Map out-of-range channel numbers onto the last channel
	always_comb begin
		if (int'(idx_s1) < CHANNELS)
			ch = CH_W'(idx_s1);
		else
			ch = CH_W'(CHANNELS - 1);
	end

	mspid_calc u_calc (
		.cfg            (cfg_q),
		.state_cur      (state_q[ch]),
		.measured_speed (speed_s1),
		.speed_err      (err_s1),
		.state_nxt      (state_nxt),
		.res            (res)
	);

	// Channel state, written as the step completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++)
				state_q[c] <= '0;
		end else if (advance) begin
			state_q[ch] <= state_nxt;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (drive.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			channel_q <= idx_s1;
			res_q     <= res;
		end
	end

	assign drive.valid           = out_valid_q;
	assign drive.channel_out     = channel_q;
	assign drive.drive_magnitude = res_q.drive_magnitude;
	assign drive.drive_reverse   = res_q.drive_reverse;
	assign drive.drive_clamped   = res_q.drive_clamped;

endmodule

[hw/rtl/mspid_checker.sv]
// Port-level checks for the motor speed regulator, bound to its top level.
// Depends on motor_speed_pid_with_ramp's ports only.
module mspid_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       drive_valid,
	input logic       drive_ready,
	input logic       channel_out,
	input logic [7:0] drive_magnitude,
	input logic       drive_reverse,
	input logic       drive_clamped
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=> drive_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && !drive_ready |=> $stable(channel_out) && $stable(drive_magnitude)
			&& $stable(drive_reverse) && $stable(drive_clamped))
		else $error("result payload changed while stalled");

	// Saturation always lands on full scale
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_clamped |-> drive_magnitude == 8'd255)
		else $error("clamped drive below full scale");

	// Zero drive is forward
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid && drive_magnitude == 8'd0 |-> !drive_reverse)
		else $error("reverse flag on zero drive");

endmodule

bind motor_speed_pid_with_ramp mspid_checker u_mspid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.drive_valid     (drive.valid),
	.drive_ready     (drive.ready),
	.channel_out     (drive.channel_out),
	.drive_magnitude (drive.drive_magnitude),
	.drive_reverse   (drive.drive_reverse),
	.drive_clamped   (drive.drive_clamped)
);

[dv/motor_speed_pid_with_ramp_test.sv]
// Self-checking testbench for motor_speed_pid_with_ramp: directed table, random regulation
// phases and a full-scale integral run, all scored against a cycle-free predictor.
// Depends on mspid_pkg, mspid_if and the motor_speed_pid_with_ramp RTL.
`timescale 1ns / 1ps

module motor_speed_pid_with_ramp_test;
	import mspid_pkg::*;

	localparam int NUM_CH = CHANNELS_DEF;
	localparam longint Q17_ONE = 64'sd131072;
	localparam longint INTEG_MAX = 64'sd2147483647;
	localparam longint INTEG_MIN = -64'sd2147483648;

	// Indexes past the last register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic                   ch;
		logic signed [15:0]     spd;
		logic signed [15:0]     err;
		bit                     fixed;
		drive_res_t             res;
	} plan_row_t;

	typedef struct packed {
		logic       channel;
		drive_res_t res;
	} drive_exp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mspid_tick_if  tick_ch();
	mspid_drive_if drive_ch();

	motor_speed_pid_with_ramp #(.CHANNELS(NUM_CH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.drive     (drive_ch)
	);

	// Predictor copy of the registers and of the per-channel state
	cfg_t                cfg_model;
	logic signed [31:0]  integ    [NUM_CH];
	logic signed [15:0]  prev_err [NUM_CH];
	logic signed [15:0]  prev_spd [NUM_CH];
	logic signed [8:0]   level    [NUM_CH];

	drive_exp_t drive_expected[$];
	plan_row_t  plan[$];
	logic signed [15:0] spd_walk [NUM_CH];

	bit calm = 1'b0;
	int ticks_sent = 0, pid_ticks = 0, ramp_ticks = 0, reg_writes = 0;
	int results_seen = 0, clamped_seen = 0, integ_sat_hi = 0, integ_sat_lo = 0;
	int mismatches = 0;

	// Compute the drive for one tick and advance the channel state
	function automatic drive_exp_t regulate(input logic ch, input logic signed [15:0] spd,
			input logic signed [15:0] err);
		longint sum, delta, acc, drv, mag;
		drive_exp_t r;
		r.channel = ch;
		r.res.drive_clamped = 1'b0;
		if (cfg_model.control_mode == MODE_PID) begin
			sum = longint'(integ[ch]) + longint'(err) + longint'(prev_err[ch]);
			if (sum > INTEG_MAX) begin
				sum = INTEG_MAX;
				integ_sat_hi++;
			end else if (sum < INTEG_MIN) begin
				sum = INTEG_MIN;
				integ_sat_lo++;
			end
			delta = longint'(spd) - longint'(prev_spd[ch]);
			acc = 2 * longint'(cfg_model.prop_gain) * longint'(err)
				+ longint'(cfg_model.int_gain) * sum
				- 2 * longint'(cfg_model.deriv_gain) * delta;
			// Integer division truncates toward zero
			drv = acc / Q17_ONE;
			integ[ch] = sum[31:0];
			prev_err[ch] = err;
			prev_spd[ch] = spd;
			pid_ticks++;
		end else begin
			// Ramp leaves the PID state alone; only the stored drive moves
			drv = longint'(level[ch]);
			if (longint'(err) > longint'(cfg_model.ramp_limit))
				drv += longint'(cfg_model.ramp_step);
			else if (longint'(err) < -longint'(cfg_model.ramp_limit))
				drv -= longint'(cfg_model.ramp_step);
			ramp_ticks++;
		end
		if (drv > DRIVE_MAX) begin
			drv = DRIVE_MAX;
			r.res.drive_clamped = 1'b1;
		end else if (drv < -DRIVE_MAX) begin
			drv = -DRIVE_MAX;
			r.res.drive_clamped = 1'b1;
		end
		level[ch] = drv[8:0];
		mag = (drv < 0) ? -drv : drv;
		r.res.drive_magnitude = mag[7:0];
		r.res.drive_reverse = (drv < 0);
		return r;
	endfunction

	function automatic plan_row_t tk(input logic ch, input logic signed [15:0] spd,
			input logic signed [15:0] err);
		plan_row_t row;
		row = '0;
		row.kind = ROW_TICK;
		row.ch = ch;
		row.spd = spd;
		row.err = err;
		return row;
	endfunction

	function automatic plan_row_t tkf(input logic ch, input logic signed [15:0] spd,
			input logic signed [15:0] err, input logic [7:0] mag, input logic rev,
			input logic clamp);
		plan_row_t row;
		row = tk(ch, spd, err);
		row.fixed = 1'b1;
		row.res = '{mag, rev, clamp};
		return row;
	endfunction

	function automatic plan_row_t rg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 1024));
		endcase
	endfunction

	// Hold the sender until every outstanding result has come back
	task automatic drain_results();
		tick_ch.valid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_CONTROL_MODE: cfg_model.control_mode = data[0];
			REG_PROP_GAIN:    cfg_model.prop_gain = data;
			REG_INT_GAIN:     cfg_model.int_gain = data;
			REG_DERIV_GAIN:   cfg_model.deriv_gain = data;
			REG_RAMP_LIMIT:   cfg_model.ramp_limit = data[14:0];
			REG_RAMP_STEP:    cfg_model.ramp_step = data[7:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Offer one tick, wait for its transfer, then queue what it must produce
	task automatic send_tick(input logic ch, input logic signed [15:0] spd,
			input logic signed [15:0] err, input bit use_fixed, input drive_res_t fixed_res);
		int gap;
		drive_exp_t exp_r;
		gap = calm ? 0 : $urandom_range(0, 15);
		cfg_we <= 1'b0;
		if (gap != 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.motor_index <= ch;
		tick_ch.measured_speed <= spd;
		tick_ch.speed_err <= err;
		do @(posedge clk); while (!tick_ch.ready);
		exp_r = regulate(ch, spd, err);
		if (use_fixed)
			exp_r.res = fixed_res;
		drive_expected.push_back(exp_r);
		ticks_sent++;
	endtask

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#(20_000_000);
		$display("motor_speed_pid_with_ramp_test: errors");
		$finish;
	end

	// Result side: stall a random number of cycles before taking each result
	initial begin
		int stall;
		drive_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if (stall != 0) begin
				drive_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			drive_ch.ready <= 1'b1;
			do @(posedge clk); while (!drive_ch.valid);
		end
	end

	// Score every result transfer against the oldest expectation
	always @(posedge clk) begin
		drive_exp_t want;
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			results_seen++;
			if (drive_ch.drive_clamped)
				clamped_seen++;
			if (drive_expected.size() == 0) begin
				$error("drive result with nothing outstanding: channel %0d magnitude %0d",
					drive_ch.channel_out, drive_ch.drive_magnitude);
				mismatches++;
			end else begin
				want = drive_expected.pop_front();
				if (drive_ch.channel_out !== want.channel) begin
					$error("channel_out: expected %0d, got %0d", want.channel,
						drive_ch.channel_out);
					mismatches++;
				end
				if (drive_ch.drive_magnitude !== want.res.drive_magnitude) begin
					$error("drive_magnitude: expected %0d, got %0d", want.res.drive_magnitude,
						drive_ch.drive_magnitude);
					mismatches++;
				end
				if (drive_ch.drive_reverse !== want.res.drive_reverse) begin
					$error("drive_reverse: expected %0d, got %0d", want.res.drive_reverse,
						drive_ch.drive_reverse);
					mismatches++;
				end
				if (drive_ch.drive_clamped !== want.res.drive_clamped) begin
					$error("drive_clamped: expected %0d, got %0d", want.res.drive_clamped,
						drive_ch.drive_clamped);
					mismatches++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int phase, n, k, sel, tmp;
		logic c;
		logic signed [15:0] e, s;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CONTROL_MODE;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.motor_index = 1'b0;
		tick_ch.measured_speed = '0;
		tick_ch.speed_err = '0;
		cfg_model = '{MODE_PID, PROP_GAIN_RST, INT_GAIN_RST, DERIV_GAIN_RST,
			RAMP_LIMIT_RST, RAMP_STEP_RST};
		for (int i = 0; i < NUM_CH; i++) begin
			integ[i] = '0;
			prev_err[i] = '0;
			prev_spd[i] = '0;
			level[i] = '0;
			spd_walk[i] = '0;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, gain extremes, ramp dead band edges and saturation,
		// dropped writes to unused indexes, PID state untouched across a ramp stretch
		plan = '{
			tkf(1'b0, 0, 0, 8'd0, 1'b0, 1'b0),
			tkf(1'b0, 0, 32767, 8'd255, 1'b0, 1'b1),
			tkf(1'b1, 0, -32768, 8'd255, 1'b1, 1'b1),
			tk(1'b0, 32767, 0),
			tk(1'b1, -32768, 32767),
			tk(1'b0, -32768, -32768),
			rg(REG_PROP_GAIN, 16'd0),
			rg(REG_INT_GAIN, 16'd0),
			rg(REG_DERIV_GAIN, 16'hFFFF),
			tkf(1'b0, 32767, 0, 8'd255, 1'b1, 1'b1),
			rg(REG_PROP_GAIN, 16'hFFFF),
			rg(REG_INT_GAIN, 16'hFFFF),
			rg(REG_DERIV_GAIN, 16'd0),
			tk(1'b1, 0, 1),
			tk(1'b1, 0, -1),
			rg(REG_CONTROL_MODE, 16'(MODE_RAMP)),
			rg(REG_RAMP_LIMIT, 16'h7FFF),
			rg(REG_RAMP_STEP, 16'd255),
			tk(1'b0, 1234, 32767),
			tk(1'b0, -1, -32768),
			tk(1'b0, 300, -32768),
			rg(REG_RAMP_LIMIT, 16'd0),
			rg(REG_RAMP_STEP, 16'd0),
			tk(1'b1, 5, 100),
			rg(REG_RAMP_STEP, 16'd255),
			tk(1'b1, 0, 0),
			tk(1'b1, 0, 1),
			tk(1'b1, 0, 1),
			rg(REG_SPARE_6, 16'hFFFF),
			rg(REG_SPARE_7, 16'h0000),
			rg(REG_RAMP_LIMIT, 16'(RAMP_LIMIT_RST)),
			rg(REG_RAMP_STEP, 16'(RAMP_STEP_RST)),
			tk(1'b0, 7, 38),
			tk(1'b0, 7, -38),
			tk(1'b0, 7, 39),
			tk(1'b0, 7, -39),
			rg(REG_CONTROL_MODE, 16'(MODE_PID)),
			rg(REG_PROP_GAIN, PROP_GAIN_RST),
			rg(REG_INT_GAIN, INT_GAIN_RST),
			rg(REG_DERIV_GAIN, DERIV_GAIN_RST),
			tk(1'b0, 100, -200),
			tk(1'b1, -100, 200)
		};
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG)
				cfg_write(plan[i].idx, plan[i].data);
			else
				send_tick(plan[i].ch, plan[i].spd, plan[i].err, plan[i].fixed, plan[i].res);
		end

		// Random phases: fresh register settings, then a run of ticks on both channels
		for (phase = 0; phase < 10; phase++) begin
			calm = ($urandom_range(0, 3) == 0);
			cfg_write(REG_CONTROL_MODE, 16'($urandom));
			cfg_write(REG_PROP_GAIN, pick_gain());
			cfg_write(REG_INT_GAIN, pick_gain());
			cfg_write(REG_DERIV_GAIN, pick_gain());
			case ($urandom_range(0, 3))
				0: cfg_write(REG_RAMP_LIMIT, 16'hFFFF);
				1: cfg_write(REG_RAMP_LIMIT, 16'd0);
				2: cfg_write(REG_RAMP_LIMIT, 16'($urandom));
				default: cfg_write(REG_RAMP_LIMIT, 16'($urandom_range(0, 600)));
			endcase
			case ($urandom_range(0, 3))
				0: cfg_write(REG_RAMP_STEP, 16'd0);
				1: cfg_write(REG_RAMP_STEP, 16'd255);
				2: cfg_write(REG_RAMP_STEP, 16'($urandom));
				default: cfg_write(REG_RAMP_STEP, 16'($urandom_range(1, 8)));
			endcase
			n = $urandom_range(110, 140);
			for (k = 0; k < n; k++) begin
				c = 1'($urandom_range(0, 1));
				// Speed mostly drifts slowly; now and then it jumps anywhere
				if ($urandom_range(0, 15) == 0)
					spd_walk[c] = 16'($urandom);
				else
					spd_walk[c] = spd_walk[c] + 16'($urandom_range(0, 64)) - 16'sd32;
				sel = $urandom_range(0, 15);
				if (sel == 0) begin
					e = 16'($urandom);
				end else if (sel < 5) begin
					// Sit on or next to the ramp dead band edge
					tmp = int'(cfg_model.ramp_limit) + int'($urandom_range(0, 2)) - 1;
					if ($urandom_range(0, 1) == 1)
						tmp = -tmp;
					e = 16'(tmp);
				end else begin
					e = 16'($urandom_range(0, 1024)) - 16'sd512;
				end
				send_tick(c, spd_walk[c], e, 1'b0, '0);
				if ($urandom_range(0, 99) == 0)
					drain_results();
			end
		end

		// Push both integrals hard with full-scale errors of opposite sign
		cfg_write(REG_CONTROL_MODE, 16'(MODE_PID));
		cfg_write(REG_PROP_GAIN, pick_gain());
		cfg_write(REG_INT_GAIN, pick_gain());
		cfg_write(REG_DERIV_GAIN, pick_gain());
		calm = 1'b1;
		for (k = 0; k < 64; k++) begin
			c = k[0];
			s = 16'($urandom);
			if (c)
				e = 16'sh8000 + 16'($urandom_range(0, 767));
			else
				e = 16'sh7FFF - 16'($urandom_range(0, 767));
			send_tick(c, s, e, 1'b0, '0);
		end
		// Then back off
		calm = 1'b0;
		for (k = 0; k < 32; k++) begin
			c = k[0];
			e = 16'($urandom_range(0, 20000));
			if (!c)
				e = -e;
			send_tick(c, 16'($urandom), e, 1'b0, '0);
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("run covered %0d ticks (%0d PID, %0d ramp) over %0d register writes",
			ticks_sent, pid_ticks, ramp_ticks, reg_writes);
		$display("%0d results checked, %0d clamped; integral pinned high %0d, low %0d times",
			results_seen, clamped_seen, integ_sat_hi, integ_sat_lo);
		if (mismatches == 0 && drive_expected.size() == 0) begin
			$display("motor_speed_pid_with_ramp_test: clean");
		end else begin
			$display("motor_speed_pid_with_ramp_test: errors");
		end
		$finish;
	end

endmodule
